FILE: src/stt_pkg.sv
// shared types and constants for the source text tokeniser
// no dependencies
package stt_pkg;

   localparam logic [3:0] M_IDLE  = 4'd0;
   localparam logic [3:0] M_OP    = 4'd1;
   localparam logic [3:0] M_LINE  = 4'd2;
   localparam logic [3:0] M_BLOCK = 4'd3;
   localparam logic [3:0] M_BSTAR = 4'd4;
   localparam logic [3:0] M_STR   = 4'd5;
   localparam logic [3:0] M_INT   = 4'd6;
   localparam logic [3:0] M_DOT   = 4'd7;
   localparam logic [3:0] M_FRAC  = 4'd8;
   localparam logic [3:0] M_IDENT = 4'd9;

   localparam logic [5:0] K_AND    = 6'd0;
   localparam logic [5:0] K_XOR    = 6'd1;
   localparam logic [5:0] K_OR     = 6'd2;
   localparam logic [5:0] K_TILDE  = 6'd3;
   localparam logic [5:0] K_PCT    = 6'd4;
   localparam logic [5:0] K_LPAR   = 6'd5;
   localparam logic [5:0] K_RPAR   = 6'd6;
   localparam logic [5:0] K_LBRACE = 6'd7;
   localparam logic [5:0] K_RBRACE = 6'd8;
   localparam logic [5:0] K_COMMA  = 6'd9;
   localparam logic [5:0] K_DOT    = 6'd10;
   localparam logic [5:0] K_MINUS  = 6'd11;
   localparam logic [5:0] K_DEC    = 6'd12;
   localparam logic [5:0] K_PLUS   = 6'd13;
   localparam logic [5:0] K_INC    = 6'd14;
   localparam logic [5:0] K_SEMI   = 6'd15;
   localparam logic [5:0] K_STAR   = 6'd16;
   localparam logic [5:0] K_LBRK   = 6'd17;
   localparam logic [5:0] K_RBRK   = 6'd18;
   localparam logic [5:0] K_BANG   = 6'd19;
   localparam logic [5:0] K_NE     = 6'd20;
   localparam logic [5:0] K_ASSIGN = 6'd21;
   localparam logic [5:0] K_EQ     = 6'd22;
   localparam logic [5:0] K_LT     = 6'd23;
   localparam logic [5:0] K_LE     = 6'd24;
   localparam logic [5:0] K_SHL    = 6'd25;
   localparam logic [5:0] K_GT     = 6'd26;
   localparam logic [5:0] K_GE     = 6'd27;
   localparam logic [5:0] K_SHR    = 6'd28;
   localparam logic [5:0] K_SLASH  = 6'd29;
   localparam logic [5:0] K_STRING = 6'd30;
   localparam logic [5:0] K_NUMBER = 6'd31;
   localparam logic [5:0] K_IDENT  = 6'd32;
   localparam logic [5:0] K_EOF    = 6'd33;

   localparam logic [1:0] E_NONE  = 2'd0;
   localparam logic [1:0] E_BYTE  = 2'd1;
   localparam logic [1:0] E_STR   = 2'd2;
   localparam logic [1:0] E_CMNT  = 2'd3;

   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOT    = 8'h2E;

   // one byte as classified by the front end
   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
      logic       digit;
      logic       alnum;
      logic       single;
      logic [5:0] single_kind;
   } class_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [1:0]  err;
      logic [31:0] start;
      logic [31:0] length;
      logic [31:0] line;
      logic        last;
   } token_type;

   function automatic logic [5:0] held_kind(input logic [7:0] h);
      case (h)
         8'h2D:   held_kind = K_MINUS;
         8'h2B:   held_kind = K_PLUS;
         8'h21:   held_kind = K_BANG;
         8'h3D:   held_kind = K_ASSIGN;
         8'h3C:   held_kind = K_LT;
         8'h3E:   held_kind = K_GT;
         default: held_kind = K_SLASH;
      endcase
   endfunction

endpackage

FILE: src/stt_if.sv
// valid/ready channel interfaces for input bytes and output tokens
// no dependencies
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_source;
   modport source (output valid, char_byte, end_of_source, input ready);
   modport sink (input valid, char_byte, end_of_source, output ready);
endinterface

interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [1:0]  error_code;
   logic [31:0] token_start;
   logic [31:0] token_length;
   logic [31:0] token_line;
   logic        last_of_run;
   modport source (output valid, token_kind, error_code, token_start, token_length,
                   token_line, last_of_run, input ready);
   modport sink (input valid, token_kind, error_code, token_start, token_length,
                 token_line, last_of_run, output ready);
endinterface

FILE: src/stt_front.sv
// front end: accepts words, classifies each byte, writes a two-deep queue
// depends on stt_pkg
module stt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         in_char,
   input  logic               in_eos,
   output logic               q_valid,
   input  logic               q_pop,
   output stt_pkg::class_type q_data
);
   import stt_pkg::*;

   class_type  c;
   class_type  slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push, pop;

   always_comb begin
      c = '0;
      c.ch = in_char;
      c.eos = in_eos;
      c.digit = in_char inside {[8'h30:8'h39]};
      c.alnum = c.digit || (in_char inside {[8'h61:8'h7A]}) ||
                (in_char inside {[8'h41:8'h5A]}) || in_char == CH_USCORE;
      c.single = 1'b1;
      case (in_char)
         8'h26:   c.single_kind = K_AND;
         8'h5E:   c.single_kind = K_XOR;
         8'h7C:   c.single_kind = K_OR;
         8'h7E:   c.single_kind = K_TILDE;
         8'h25:   c.single_kind = K_PCT;
         8'h28:   c.single_kind = K_LPAR;
         8'h29:   c.single_kind = K_RPAR;
         8'h7B:   c.single_kind = K_LBRACE;
         8'h7D:   c.single_kind = K_RBRACE;
         8'h2C:   c.single_kind = K_COMMA;
         CH_DOT:  c.single_kind = K_DOT;
         8'h3B:   c.single_kind = K_SEMI;
         CH_STAR: c.single_kind = K_STAR;
         8'h5B:   c.single_kind = K_LBRK;
         8'h5D:   c.single_kind = K_RBRK;
         default: begin
            c.single = 1'b0;
            c.single_kind = K_AND;
         end
      endcase
   end

   assign in_ready = cnt_ff != 2'd2;
   assign push = in_valid && in_ready;
   assign pop = q_pop && q_valid;
   assign q_valid = cnt_ff != 2'd0;
   assign q_data = slot_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
      if (push) slot_ff[wp_ff] <= c;
   end
endmodule

FILE: src/stt_back.sv
// back end: scanner state, emits up to three tokens per byte, one per cycle while out_ready is high
// depends on stt_pkg
module stt_back #(
   parameter int POSITION_BITS = 32,
   parameter int LINE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_pop,
   input  stt_pkg::class_type q_data,
   output logic               out_valid,
   input  logic               out_ready,
   output stt_pkg::token_type out_data
);
   import stt_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [LINE_BITS-1:0] LN_MAX = '1;

   logic [3:0]               mode_ff, mode_in;
   logic [7:0]               held_ff, held_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;

   // tokens computed for the current byte, presented one per cycle while out_ready is high
   token_type tok [3];
   logic [1:0] ntok;
   logic [1:0] idx_ff, idx_in;
   logic       out_fire, done;

   logic [POSITION_BITS-1:0] d, d_incl, d_m1, pos_m1;
   logic [7:0] c;
   logic       line_bump;

   function automatic logic [31:0] sat_pos(input logic [POSITION_BITS-1:0] v);
      if (POSITION_BITS > 32) begin
         sat_pos = (v > POSITION_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(v);
      end else begin
         sat_pos = 32'(v);
      end
   endfunction

   function automatic logic [31:0] sat_line(input logic [LINE_BITS-1:0] v);
      if (LINE_BITS > 32) begin
         sat_line = (v > LINE_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(v);
      end else begin
         sat_line = 32'(v);
      end
   endfunction

   always_comb begin
      d = pos_ff - start_ff;
      d_incl = (d < POS_MAX) ? d + 1'b1 : d;
      d_m1 = (d != '0) ? d - 1'b1 : '0;
      pos_m1 = (pos_ff != '0) ? pos_ff - 1'b1 : '0;
   end

   always_comb begin
      logic [5:0]  k;
      logic [1:0]  e;
      logic [POSITION_BITS-1:0] s, l;
      logic        em, rescan, pair;
      k = '0; e = '0; s = '0; l = '0; em = 1'b0; rescan = 1'b0; pair = 1'b0;
      c = q_data.ch;
      mode_in = mode_ff;
      held_in = held_ff;
      start_in = start_ff;
      line_bump = 1'b0;
      ntok = 2'd0;
      for (int i = 0; i < 3; i++) tok[i] = '0;

      if (q_data.eos) begin
         case (mode_ff)
            M_OP:    begin em = 1'b1; k = held_kind(held_ff); s = start_ff; l = d; end
            M_STR:   begin em = 1'b1; e = E_STR; s = start_ff; l = d; end
            M_BLOCK, M_BSTAR: begin em = 1'b1; e = E_CMNT; s = start_ff; l = d; end
            M_INT, M_FRAC: begin em = 1'b1; k = K_NUMBER; s = start_ff; l = d; end
            M_IDENT: begin em = 1'b1; k = K_IDENT; s = start_ff; l = d; end
            default: ;
         endcase
         if (mode_ff == M_DOT) begin
            tok[0] = '{K_NUMBER, E_NONE, sat_pos(start_ff), sat_pos(d_m1),
                       sat_line(line_ff), 1'b0};
            tok[1] = '{K_DOT, E_NONE, sat_pos(pos_m1), 32'd1, sat_line(line_ff), 1'b0};
            ntok = 2'd2;
         end else if (em) begin
            tok[0] = '{k, e, sat_pos(s), sat_pos(l), sat_line(line_ff), 1'b0};
            ntok = 2'd1;
         end
         tok[ntok] = '{K_EOF, E_NONE, sat_pos(pos_ff), 32'd0, sat_line(line_ff), 1'b1};
         ntok = ntok + 2'd1;
         mode_in = M_IDLE;
         held_in = '0;
         start_in = '0;
      end else begin
         // first, tokens closed by this byte in the current mode
         case (mode_ff)
            M_OP: begin
               pair = 1'b1;
               if (held_ff == 8'h2D && c == 8'h2D) k = K_DEC;
               else if (held_ff == 8'h2B && c == 8'h2B) k = K_INC;
               else if (held_ff == 8'h21 && c == 8'h3D) k = K_NE;
               else if (held_ff == 8'h3D && c == 8'h3D) k = K_EQ;
               else if (held_ff == 8'h3C && c == 8'h3D) k = K_LE;
               else if (held_ff == 8'h3C && c == 8'h3C) k = K_SHL;
               else if (held_ff == 8'h3E && c == 8'h3D) k = K_GE;
               else if (held_ff == 8'h3E && c == 8'h3E) k = K_SHR;
               else pair = 1'b0;
               if (held_ff == CH_SLASH && c == CH_SLASH) mode_in = M_LINE;
               else if (held_ff == CH_SLASH && c == CH_STAR) mode_in = M_BLOCK;
               else if (pair) begin
                  tok[0] = '{k, E_NONE, sat_pos(start_ff), sat_pos(d_incl),
                             sat_line(line_ff), 1'b0};
                  ntok = 2'd1;
                  mode_in = M_IDLE;
               end else begin
                  tok[0] = '{held_kind(held_ff), E_NONE, sat_pos(start_ff), sat_pos(d),
                             sat_line(line_ff), 1'b0};
                  ntok = 2'd1;
                  rescan = 1'b1;
               end
            end
            M_LINE: if (c == 8'h0A) begin line_bump = 1'b1; mode_in = M_IDLE; end
            M_BLOCK: begin
               if (c == 8'h0A) line_bump = 1'b1;
               else if (c == CH_STAR) mode_in = M_BSTAR;
            end
            M_BSTAR: begin
               if (c == CH_SLASH) mode_in = M_IDLE;
               else if (c != CH_STAR) begin
                  line_bump = c == 8'h0A;
                  mode_in = M_BLOCK;
               end
            end
            M_STR: begin
               if (c == 8'h22) begin
                  tok[0] = '{K_STRING, E_NONE, sat_pos(start_ff), sat_pos(d_incl),
                             sat_line(line_ff), 1'b0};
                  ntok = 2'd1;
                  mode_in = M_IDLE;
               end else if (c == 8'h0A) line_bump = 1'b1;
            end
            M_INT, M_FRAC, M_IDENT: begin
               if (mode_ff == M_IDENT ? q_data.alnum : q_data.digit) begin
               end else if (mode_ff == M_INT && c == CH_DOT) mode_in = M_DOT;
               else begin
                  tok[0] = '{(mode_ff == M_IDENT) ? K_IDENT : K_NUMBER, E_NONE,
                             sat_pos(start_ff), sat_pos(d), sat_line(line_ff), 1'b0};
                  ntok = 2'd1;
                  rescan = 1'b1;
               end
            end
            M_DOT: begin
               if (q_data.digit) mode_in = M_FRAC;
               else begin
                  tok[0] = '{K_NUMBER, E_NONE, sat_pos(start_ff), sat_pos(d_m1),
                             sat_line(line_ff), 1'b0};
                  tok[1] = '{K_DOT, E_NONE, sat_pos(pos_m1), 32'd1,
                             sat_line(line_ff), 1'b0};
                  ntok = 2'd2;
                  rescan = 1'b1;
               end
            end
            default: rescan = 1'b1;
         endcase
         // then the byte scanned afresh from idle
         if (rescan) begin
            start_in = pos_ff;
            mode_in = M_IDLE;
            if (q_data.single) begin
               tok[ntok] = '{q_data.single_kind, E_NONE, sat_pos(pos_ff), 32'd1,
                             sat_line(line_ff), 1'b0};
               ntok = ntok + 2'd1;
            end else if (c inside {8'h2D, 8'h2B, 8'h21, 8'h3D, 8'h3C, 8'h3E, CH_SLASH})
            begin
               mode_in = M_OP;
               held_in = c;
            end else if (c inside {8'h20, 8'h0D, 8'h09}) begin
            end else if (c == 8'h0A) line_bump = 1'b1;
            else if (c == 8'h22) mode_in = M_STR;
            else if (q_data.digit) mode_in = M_INT;
            else if (q_data.alnum) mode_in = M_IDENT;
            else begin
               tok[ntok] = '{K_AND, E_BYTE, sat_pos(pos_ff), 32'd1,
                             sat_line(line_ff), 1'b0};
               ntok = ntok + 2'd1;
            end
         end
         if (ntok != 2'd0) tok[ntok - 2'd1].last = 1'b1;
      end
   end

   assign out_valid = q_valid && ntok != 2'd0;
   assign out_data = tok[idx_ff];
   assign out_fire = out_valid && out_ready;
   assign done = ntok == 2'd0 || (out_fire && idx_ff == ntok - 2'd1);
   assign q_pop = q_valid && done;

   always_comb begin
      idx_in = idx_ff;
      if (q_pop) idx_in = '0;
      else if (out_fire) idx_in = idx_ff + 2'd1;
      pos_in = q_data.eos ? '0 : ((pos_ff < POS_MAX) ? pos_ff + 1'b1 : pos_ff);
      line_in = q_data.eos ? LINE_BITS'(1) :
                ((line_bump && line_ff < LN_MAX) ? line_ff + 1'b1 : line_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         held_ff <= '0;
         pos_ff <= '0;
         start_ff <= '0;
         line_ff <= LINE_BITS'(1);
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         if (q_pop) begin
            mode_ff <= mode_in;
            held_ff <= held_in;
            pos_ff <= pos_in;
            start_ff <= start_in;
            line_ff <= line_in;
         end
      end
   end
endmodule

FILE: src/stt_out.sv
// output pipeline register between the scanner and the result channel
// depends on stt_pkg
module stt_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  stt_pkg::token_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output stt_pkg::token_type out_data
);
   import stt_pkg::*;

   token_type data_ff;
   logic      valid_ff;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
      if (in_ready && in_valid) data_ff <= in_data;
   end
endmodule

FILE: src/source_text_tokenizer.sv
// streaming tokeniser: one byte word per cycle in, one token word per cycle out, unless stalled
// path: a closing byte is registered in the front queue, its token in the output register
// throughput: one byte per cycle when not held back; a byte that closes up to three tokens
// (or the end marker) holds the scanner until each has entered the output register
// reset: synchronous, clears scan state to idle, offset 0, line 1, queues empty
// depends on stt_pkg, stt_if, stt_front, stt_back, stt_out
module source_text_tokenizer #(
   parameter int POSITION_BITS = 32,
   parameter int LINE_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   stt_req_if.sink    req,
   stt_rsp_if.source  rsp
);
   import stt_pkg::*;

   // front to back queue
   logic      q_valid, q_pop;
   class_type q_data;
   // back to output register
   logic      t_valid, t_ready;
   token_type t_data, o_data;

   stt_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready),
      .in_char (req.char_byte), .in_eos (req.end_of_source),
      .q_valid, .q_pop, .q_data
   );

   // scanner state machine, one token word per cycle unless the output stalls
   stt_back #(.POSITION_BITS(POSITION_BITS), .LINE_BITS(LINE_BITS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data,
      .out_valid (t_valid), .out_ready (t_ready), .out_data (t_data)
   );

   // output register; the scanner stalls while a token waits in it and rsp.ready is low
   stt_out u_out (
      .clock, .reset,
      .in_valid (t_valid), .in_ready (t_ready), .in_data (t_data),
      .out_valid (rsp.valid), .out_ready (rsp.ready), .out_data (o_data)
   );

   assign rsp.token_kind   = o_data.kind;
   assign rsp.error_code   = o_data.err;
   assign rsp.token_start  = o_data.start;
   assign rsp.token_length = o_data.length;
   assign rsp.token_line   = o_data.line;
   assign rsp.last_of_run  = o_data.last;
endmodule
